FILE: sv/olisd_pkg.sv
// ----------------------------------------------------------------------------
// olisd_pkg
// Command and status codes for the ordered list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olisd_pkg;

	// Command codes carried on the input item
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	// Status codes carried on the result item
	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_MISS = 2'd1,
		STS_FULL = 2'd2
	} status_t;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned COUNT_W = 5;

endpackage

`default_nettype wire

FILE: sv/olisd_ram.sv
// ----------------------------------------------------------------------------
// olisd_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olisd_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: sv/ordered_list_insert_search_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_search_delete_core
// Bounded ordered list held in a synchronous RAM. Insert appends at the
// tail, search finds the first equal entry, delete removes it and closes
// the gap by moving later entries down one place.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-------------------------------------------
//  input   | in_valid/in_ready  | command[1:0], value[31:0] (signed)
//  result  | out_valid/out_ready| status[1:0], position[3:0], entry_count[4:0]
//
//  Insert, unknown commands and search/delete on an empty list go straight
//  to the finishing step. Search and delete scan from position 0 to the
//  first hit or the tail; a delete hit then moves later entries down. The
//  single RAM read port allows one entry compared or moved per cycle.
//  Reset clears the count and the control; RAM contents need no clearing.
//  A result held by a stalled output blocks only the finishing step; one item
//  is worked on at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_search_delete_core #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  command,
	input  wire logic signed [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [3:0]       position,
	output logic [4:0]       entry_count
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t                          state_q;
	logic [1:0]                      cmd_q;
	logic signed [31:0]              value_q;
	logic [CW-1:0]                   count_q;
	logic [AW-1:0]                   cmp_addr_s1;
	olisd_pkg::status_t              res_status_q;
	logic [AW-1:0]                   res_pos_q;
	logic                            out_valid_q;
	olisd_pkg::status_t              status_q;
	logic [3:0]                      position_q;
	logic [4:0]                      entry_count_q;

	logic                            accept;
	logic [CW-1:0]                   last_cnt;
	logic                            is_hit;
	logic                            cmp_last;
	logic                            shift_last;
	logic                            is_full;
	logic [AW+3:0]                   pos_ext;
	logic [CW+4:0]                   cnt_ext;

	logic                            ram_we;
	logic [AW-1:0]                   ram_wr_addr;
	logic [31:0]                     ram_wr_data;
	logic [AW-1:0]                   ram_rd_addr;
	logic [31:0]                     ram_rd_data;

	olisd_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (olisd_pkg::DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Handshake and compare terms
	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign last_cnt   = count_q - CW'(1);
	assign is_hit     = (ram_rd_data == value_q);
	assign cmp_last   = (CW'(cmp_addr_s1) == last_cnt);
	assign shift_last = ((CW'(cmp_addr_s1) + CW'(1)) == last_cnt);
	assign is_full    = (count_q >= CW'(CAPACITY));
	assign pos_ext    = {4'd0, res_pos_q};
	assign cnt_ext    = {5'd0, count_q};

	// Drive the RAM ports from the current step
	always_comb begin
		ram_we      = 1'b0;
		ram_wr_addr = cmp_addr_s1;
		ram_wr_data = ram_rd_data;
		ram_rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && command == olisd_pkg::CMD_INSERT && !is_full) begin
					ram_we      = 1'b1;
					ram_wr_addr = count_q[AW-1:0];
					ram_wr_data = value;
				end
			end
			S_SCAN: begin
				ram_rd_addr = cmp_addr_s1 + AW'(1);
			end
			S_SHIFT: begin
				ram_we      = 1'b1;
				ram_rd_addr = cmp_addr_s1 + AW'(2);
			end
			default: begin
				ram_rd_addr = '0;
			end
		endcase
	end

	// Sequencer, count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= '0;
			value_q       <= '0;
			count_q       <= '0;
			cmp_addr_s1   <= '0;
			res_status_q  <= olisd_pkg::STS_MISS;
			res_pos_q     <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= olisd_pkg::STS_MISS;
			position_q    <= '0;
			entry_count_q <= '0;
		end else begin
			// drop the result once taken, unless the finishing step reloads it
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q       <= command;
						value_q     <= value;
						cmp_addr_s1 <= '0;
						res_pos_q   <= '0;
						case (command)
							olisd_pkg::CMD_INSERT: begin
								if (is_full) begin
									res_status_q <= olisd_pkg::STS_FULL;
								end else begin
									count_q      <= count_q + CW'(1);
									res_status_q <= olisd_pkg::STS_OK;
								end
								state_q <= S_FINISH;
							end
							olisd_pkg::CMD_SEARCH, olisd_pkg::CMD_DELETE: begin
								if (count_q == '0) begin
									res_status_q <= olisd_pkg::STS_MISS;
									state_q      <= S_FINISH;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= olisd_pkg::STS_MISS;
								state_q      <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (is_hit) begin
						res_status_q <= olisd_pkg::STS_OK;
						res_pos_q    <= cmp_addr_s1;
						if (cmd_q == olisd_pkg::CMD_DELETE) begin
							if (cmp_last) begin
								count_q <= last_cnt;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_SHIFT;
							end
						end else begin
							state_q <= S_FINISH;
						end
					end else if (cmp_last) begin
						res_status_q <= olisd_pkg::STS_MISS;
						res_pos_q    <= '0;
						state_q      <= S_FINISH;
					end else begin
						cmp_addr_s1 <= cmp_addr_s1 + AW'(1);
					end
				end
				S_SHIFT: begin
					// move one entry down per cycle until the tail
					if (shift_last) begin
						count_q <= last_cnt;
						state_q <= S_FINISH;
					end else begin
						cmp_addr_s1 <= cmp_addr_s1 + AW'(1);
					end
				end
				S_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						position_q    <= pos_ext[3:0];
						entry_count_q <= cnt_ext[4:0];
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered list core. A behavioural copy of the
// list predicts status, position and count for every accepted command;
// the results that come out are checked in order against those predictions.
// Directed cases cover empty and full lists, duplicates and value extremes;
// random traffic sweeps the count up and down, with both sides idling and without.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned     LIST_DEPTH   = 16;
	localparam int unsigned     CYCLE_LIMIT  = 500000;
	localparam int unsigned     END_SETTLE   = 40;
	localparam logic [1:0]      CMD_UNKNOWN  = 2'd3;
	localparam logic signed [31:0] VAL_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX   = 32'sh7fff_ffff;

	typedef struct packed {
		olisd_pkg::status_t status;
		logic [3:0]         position;
		logic [4:0]         entry_count;
	} list_result_t;

	// DUT ports
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [1:0]        command     = olisd_pkg::CMD_INSERT;
	logic signed [31:0] value      = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [1:0]        status;
	logic [3:0]        position;
	logic [4:0]        entry_count;

	// Predicted list contents and pending results
	logic signed [31:0] list_entries[$];
	list_result_t       pending_results[$];
	list_result_t       oldest_result;

	// Small value set so that searches and deletes hit duplicates
	logic signed [31:0] value_pool [8] = '{VAL_MIN, VAL_MAX, 32'sd0, -32'sd1,
		32'sd1, 32'sd5, 32'sh5a5a_a5a5, -32'sd77};

	bit          idle_on      = 1'b1;
	int unsigned rx_hold_left = 0;
	int unsigned cycle_cnt    = 0;
	int unsigned err_cnt      = 0;
	int unsigned item_cnt     = 0;
	int unsigned result_cnt   = 0;
	int unsigned hit_cnt      = 0;
	int unsigned miss_cnt     = 0;
	int unsigned full_cnt     = 0;
	int unsigned peak_count   = 0;

	ordered_list_insert_search_delete_core #(
		.CAPACITY(LIST_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.position   (position),
		.entry_count(entry_count)
	);

	// Clock
	initial begin
		forever #10 clk = ~clk;
	end

	// Count cycles for the watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Abort a run that hangs
	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still due", cycle_cnt,
			pending_results.size());
		$display("[ordered_list_insert_search_delete_core] ERROR");
		$finish;
	end

	// Apply one command to the list copy and return the result it gives
	function automatic list_result_t predict_list_result(logic [1:0] cmd,
			logic signed [31:0] val);
		list_result_t res;
		int           first_hit;
		first_hit = -1;
		res.status   = olisd_pkg::STS_MISS;
		res.position = '0;
		for (int i = 0; i < list_entries.size(); i++) begin
			if (first_hit < 0 && list_entries[i] == val) first_hit = i;
		end
		case (cmd)
			olisd_pkg::CMD_INSERT: begin
				if (list_entries.size() >= LIST_DEPTH) begin
					res.status = olisd_pkg::STS_FULL;
					full_cnt++;
				end else begin
					list_entries.push_back(val);
					res.status = olisd_pkg::STS_OK;
				end
			end
			olisd_pkg::CMD_SEARCH, olisd_pkg::CMD_DELETE: begin
				if (first_hit >= 0) begin
					res.status   = olisd_pkg::STS_OK;
					res.position = first_hit[3:0];
					if (cmd == olisd_pkg::CMD_DELETE) list_entries.delete(first_hit);
					hit_cnt++;
				end else begin
					miss_cnt++;
				end
			end
			default: begin
				// unknown command: nothing changes
			end
		endcase
		res.entry_count = 5'(list_entries.size());
		if (list_entries.size() > peak_count) peak_count = list_entries.size();
		return res;
	endfunction

	// Print one mismatch line and count it
	task automatic report_mismatch(string field, int unsigned want, int unsigned got);
		err_cnt++;
		$display("[%0t] result %0d: %s expected %0d got %0d", $time, result_cnt, field,
			want, got);
	endtask

	// Offer one item, hold it until accepted, then record its prediction
	task automatic send_command(logic [1:0] cmd, logic signed [31:0] val);
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		do @(posedge clk); while (!in_ready);
		item_cnt++;
		pending_results.push_back(predict_list_result(cmd, val));
	endtask

	// Pick a random command; insert_pct steers the count up or down
	task automatic send_random_item(int unsigned insert_pct);
		logic [1:0]         cmd;
		logic signed [31:0] val;
		int unsigned        roll;
		roll = $urandom_range(0, 99);
		if (roll < 2) cmd = CMD_UNKNOWN;
		else if (roll < 2 + insert_pct) cmd = olisd_pkg::CMD_INSERT;
		else if (roll[0]) cmd = olisd_pkg::CMD_SEARCH;
		else cmd = olisd_pkg::CMD_DELETE;
		roll = $urandom_range(0, 9);
		if (cmd != olisd_pkg::CMD_INSERT && roll < 5 && list_entries.size() > 0)
			val = list_entries[$urandom_range(0, list_entries.size() - 1)];
		else if (roll < 8)
			val = value_pool[$urandom_range(0, 7)];
		else
			val = $urandom;
		send_command(cmd, val);
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Receiver: random stall bursts, plus a long hold when asked
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				out_ready <= 1'b0;
				rx_hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 17);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_cnt++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", 0, status);
			end else begin
				oldest_result = pending_results.pop_front();
				if (status !== oldest_result.status)
					report_mismatch("status", oldest_result.status, status);
				if (position !== oldest_result.position)
					report_mismatch("position", oldest_result.position, position);
				if (entry_count !== oldest_result.entry_count)
					report_mismatch("entry_count", oldest_result.entry_count, entry_count);
			end
		end
	end

	// Empty list, extremes, duplicates, unknown command, shifts on delete
	task automatic test_directed_cases();
		send_command(olisd_pkg::CMD_SEARCH, 32'sd0);
		send_command(olisd_pkg::CMD_DELETE, 32'sd0);
		send_command(CMD_UNKNOWN, VAL_MAX);
		send_command(olisd_pkg::CMD_INSERT, VAL_MIN);
		send_command(olisd_pkg::CMD_INSERT, VAL_MAX);
		send_command(olisd_pkg::CMD_INSERT, 32'sd0);
		send_command(olisd_pkg::CMD_INSERT, -32'sd1);
		send_command(olisd_pkg::CMD_INSERT, VAL_MAX);
		send_command(olisd_pkg::CMD_SEARCH, VAL_MAX);
		send_command(olisd_pkg::CMD_SEARCH, 32'sh7fff_fffe);
		send_command(olisd_pkg::CMD_SEARCH, -32'sd1);
		send_command(CMD_UNKNOWN, VAL_MAX);
		send_command(olisd_pkg::CMD_DELETE, VAL_MIN);
		send_command(olisd_pkg::CMD_SEARCH, -32'sd1);
		send_command(olisd_pkg::CMD_DELETE, VAL_MAX);
		send_command(olisd_pkg::CMD_SEARCH, VAL_MAX);
		send_command(olisd_pkg::CMD_DELETE, VAL_MAX);
		send_command(olisd_pkg::CMD_DELETE, 32'sd12345);
		send_command(olisd_pkg::CMD_SEARCH, 32'sd0);
	endtask

	// Fill to capacity, overflow, then work at both ends of the list
	task automatic test_full_list();
		while (list_entries.size() < LIST_DEPTH)
			send_command(olisd_pkg::CMD_INSERT, $urandom);
		send_command(olisd_pkg::CMD_INSERT, VAL_MIN);
		send_command(olisd_pkg::CMD_SEARCH, list_entries[LIST_DEPTH - 1]);
		send_command(CMD_UNKNOWN, 32'sd0);
		send_command(olisd_pkg::CMD_DELETE, list_entries[0]);
		send_command(olisd_pkg::CMD_INSERT, VAL_MAX);
		send_command(olisd_pkg::CMD_DELETE, list_entries[LIST_DEPTH - 1]);
	endtask

	// Random traffic; the insert share cycles so the count sweeps empty to full
	task automatic test_random_traffic(int unsigned n_items);
		for (int unsigned i = 0; i < n_items; i++) begin
			case ((i / 50) % 3)
				0:       send_random_item(70);
				1:       send_random_item(40);
				default: send_random_item(20);
			endcase
		end
	endtask

	// Hold results back for a long stretch so the core stalls its input
	task automatic test_output_backpressure();
		rx_hold_left = 300;
		repeat (40) send_random_item(50);
	endtask

	// Let the sender pause until nothing is outstanding, then resume
	task automatic test_sender_pause();
		repeat (30) send_random_item(60);
		wait_results_drained();
		repeat (30) send_random_item(30);
	endtask

	// Back-to-back traffic with both sides always ready
	task automatic test_no_idle_tail();
		idle_on = 1'b0;
		test_random_traffic(200);
	endtask

	// Main sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_list();
		test_random_traffic(780);
		test_output_backpressure();
		test_sender_pause();
		test_no_idle_tail();

		wait_results_drained();
		repeat (END_SETTLE) @(posedge clk);

		$display("run covered %0d commands and %0d results over %0d cycles", item_cnt,
			result_cnt, cycle_cnt);
		$display("matches %0d, misses %0d, full rejects %0d, peak count %0d", hit_cnt,
			miss_cnt, full_cnt, peak_count);
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("[ordered_list_insert_search_delete_core] OK");
		end else begin
			$display("[ordered_list_insert_search_delete_core] ERROR");
		end
		$finish;
	end

endmodule
